/* hdl/cab_data_block_checker_assert.svh */
// ----------------------------------------------------------------------------
// cab_data_block_checker assertion macros
// Concurrent assertion helpers on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef CAB_DATA_BLOCK_CHECKER_ASSERT_SVH
`define CAB_DATA_BLOCK_CHECKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge out of reset
`define DBC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define DBC_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define DBC_ASSERT_ALWAYS(name, cond, msg)
`define DBC_ASSERT_NEXT(name, trig, cons, msg)

`endif

`endif

/* hdl/cab_dbc_pkg.sv */
// ----------------------------------------------------------------------------
// cab_dbc_pkg
// Shared types and constants of the cabinet data block checker.
// ----------------------------------------------------------------------------
package cab_dbc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_BYTES     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_COMPRESSED     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_UNCOMPRESSED   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENFORCE_CHECKSUM   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECT_CK_SIGNATURE = 3'd4;

    localparam logic [15:0] RST_MAX_COMPRESSED   = 16'hFFFF;
    localparam logic [15:0] RST_MAX_UNCOMPRESSED = 16'h8000;

    // mszip signature bytes
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_K = 8'h4B;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_MISMATCH      = 3'd1,
        ST_CSIZE_BIG     = 3'd2,
        ST_USIZE_BIG     = 3'd3,
        ST_NO_SIGNATURE  = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        checksum_ok;
        logic [31:0] stored_checksum;
        logic [31:0] computed_checksum;
        logic [15:0] compressed_bytes;
        logic [15:0] uncompressed_bytes;
    } result_t;

endpackage

/* hdl/cab_dbc_if.sv */
// ----------------------------------------------------------------------------
// cab_dbc interfaces
// Valid/ready channels for the byte stream and for the block results.
// ----------------------------------------------------------------------------
interface cab_dbc_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);

endinterface

interface cab_dbc_result_if import cab_dbc_pkg::*; ();

    logic        valid;
    logic        ready;
    status_t     status;
    logic        checksum_ok;
    logic [31:0] stored_checksum;
    logic [31:0] computed_checksum;
    logic [15:0] compressed_bytes;
    logic [15:0] uncompressed_bytes;

    modport source (
        output valid, output status, output checksum_ok, output stored_checksum,
        output computed_checksum, output compressed_bytes, output uncompressed_bytes,
        input ready
    );
    modport sink (
        input valid, input status, input checksum_ok, input stored_checksum,
        input computed_checksum, input compressed_bytes, input uncompressed_bytes,
        output ready
    );

endinterface

/* hdl/cab_data_block_checker.sv */
// ----------------------------------------------------------------------------
// cab_data_block_checker
// Parses back-to-back cabinet data blocks and checks each block's checksum.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one byte of the block stream per item. Each block is a
//   4-byte stored checksum, 2-byte compressed size, 2-byte uncompressed size,
//   reserved bytes, then the payload. report carries one result per block.
//   cfg_write/cfg_index/cfg_data write the registers while the block is idle.
// Output: when the byte that completes the block (or trips a size limit) is
//   accepted, its result is registered (in the skid entry if report stalls).
// Throughput: one byte per cycle while stream.ready is high; each byte is
//   parsed and folded into the running checksum in the cycle it is accepted.
// Stall: an output register and a one-entry skid register hold results;
//   stream.ready drops only while both hold a result.
// Reset: registers return to their defaults, the parser waits for a block
//   header, and both result registers are empty.
// ----------------------------------------------------------------------------
module cab_data_block_checker
    import cab_dbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    cab_dbc_byte_if.sink           stream,
    cab_dbc_result_if.source       report,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "cab_data_block_checker_assert.svh"

    typedef enum logic [4:0] {
        PH_CSUM    = 5'b00001,
        PH_CSIZE   = 5'b00010,
        PH_USIZE   = 5'b00100,
        PH_RESV    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    // configuration
    logic [7:0]  reserved_bytes_reg;
    logic [15:0] max_compressed_reg;
    logic [15:0] max_uncompressed_reg;
    logic        enforce_checksum_reg;
    logic        expect_ck_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] hc_reg, hc_next;
    logic [15:0] ps_reg, ps_next;
    logic [15:0] us_reg, us_next;
    logic        sig_bad_reg, sig_bad_next;

    // result registers
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic [16:0] count_inc;
    logic [31:0] hc_upd;
    logic [15:0] ps_upd;
    logic [15:0] us_upd;
    logic        in_full_words;
    logic [1:0]  lane;
    logic [31:0] acc_upd;
    logic        sig_upd;
    logic [15:0] ps_cur;
    logic [15:0] us_cur;
    logic [31:0] fin_acc;
    logic        fin_sig;
    logic [31:0] fin_comp;
    logic        fin_ok;
    status_t     fin_status;
    logic        do_finish;
    logic        do_size_err;
    status_t     size_err_code;
    logic        emit;
    result_t     new_result;

    assign b            = stream.data_byte;
    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && stream.ready;
    assign pop          = out_valid_reg && report.ready;

    assign count_inc = {1'b0, byte_count_reg} + 17'd1;

    assign hc_upd = ((byte_count_reg == 16'd0) ? 32'd0 : hc_reg)
                    | ({24'd0, b} << {byte_count_reg[1:0], 3'b000});
    assign ps_upd = ps_reg | ({8'd0, b} << {byte_count_reg[0], 3'b000});
    assign us_upd = us_reg | ({8'd0, b} << {byte_count_reg[0], 3'b000});

    // tail bytes of a payload are packed high-first
    assign in_full_words = byte_count_reg[15:2] < ps_reg[15:2];
    assign lane    = in_full_words ? byte_count_reg[1:0]
                                   : (ps_reg[1:0] - 2'd1 - byte_count_reg[1:0]);
    assign acc_upd = acc_reg ^ ({24'd0, b} << {lane, 3'b000});
    assign sig_upd = sig_bad_reg
                     | ((byte_count_reg == 16'd0) && (b != CHAR_C))
                     | ((byte_count_reg == 16'd1) && (b != CHAR_K));

    assign ps_cur = (phase_reg == PH_CSIZE) ? ps_upd : ps_reg;
    assign us_cur = (phase_reg == PH_USIZE) ? us_upd : us_reg;

    assign fin_acc  = (phase_reg == PH_PAYLOAD) ? acc_upd : acc_reg;
    assign fin_sig  = ((phase_reg == PH_PAYLOAD) ? sig_upd : sig_bad_reg)
                      | (expect_ck_reg && (ps_cur < 16'd2));
    assign fin_comp = fin_acc ^ {us_cur, ps_cur};
    assign fin_ok   = (fin_comp == hc_reg);

    always_comb
    begin
        priority if (!fin_ok && enforce_checksum_reg)
        begin
            fin_status = ST_MISMATCH;
        end
        else if (expect_ck_reg && fin_sig)
        begin
            fin_status = ST_NO_SIGNATURE;
        end
        else
        begin
            fin_status = ST_OK;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = count_inc[15:0];
        acc_next        = acc_reg;
        hc_next         = hc_reg;
        ps_next         = ps_reg;
        us_next         = us_reg;
        sig_bad_next    = sig_bad_reg;
        do_finish       = 1'b0;
        do_size_err     = 1'b0;
        size_err_code   = ST_CSIZE_BIG;

        unique case (phase_reg)
            PH_CSUM:
            begin
                hc_next = hc_upd;
                if (byte_count_reg == 16'd0)
                begin
                    ps_next = 16'd0;
                    us_next = 16'd0;
                end
                if (byte_count_reg[1:0] == 2'd3)
                begin
                    phase_next      = PH_CSIZE;
                    byte_count_next = 16'd0;
                end
            end
            PH_CSIZE:
            begin
                ps_next = ps_upd;
                if (byte_count_reg[0])
                begin
                    if (ps_upd > max_compressed_reg)
                    begin
                        do_size_err   = 1'b1;
                        size_err_code = ST_CSIZE_BIG;
                    end
                    else
                    begin
                        phase_next      = PH_USIZE;
                        byte_count_next = 16'd0;
                    end
                end
            end
            PH_USIZE:
            begin
                us_next = us_upd;
                if (byte_count_reg[0])
                begin
                    byte_count_next = 16'd0;
                    if (us_upd > max_uncompressed_reg)
                    begin
                        do_size_err   = 1'b1;
                        size_err_code = ST_USIZE_BIG;
                    end
                    else if (reserved_bytes_reg != 8'd0)
                    begin
                        phase_next = PH_RESV;
                    end
                    else if (ps_reg == 16'd0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_RESV:
            begin
                // a lowered register ends the skip as soon as the count passes it
                if (count_inc >= {9'd0, reserved_bytes_reg})
                begin
                    byte_count_next = 16'd0;
                    if (ps_reg == 16'd0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                acc_next     = acc_upd;
                sig_bad_next = sig_upd;
                if (count_inc >= {1'b0, ps_reg})
                begin
                    do_finish = 1'b1;
                end
            end
            default:
            begin
                phase_next      = PH_CSUM;
                byte_count_next = 16'd0;
                acc_next        = 32'd0;
                sig_bad_next    = 1'b0;
            end
        endcase

        // a result restarts the parser at a header
        if (do_finish || do_size_err)
        begin
            phase_next      = PH_CSUM;
            byte_count_next = 16'd0;
            acc_next        = 32'd0;
            sig_bad_next    = 1'b0;
        end
    end

    assign emit = do_finish || do_size_err;

    always_comb
    begin
        new_result.status             = do_finish ? fin_status : size_err_code;
        new_result.checksum_ok        = do_finish && fin_ok;
        new_result.stored_checksum    = hc_reg;
        new_result.computed_checksum  = do_finish ? fin_comp : 32'd0;
        new_result.compressed_bytes   = ps_cur;
        new_result.uncompressed_bytes = us_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_bytes_reg   <= 8'd0;
            max_compressed_reg   <= RST_MAX_COMPRESSED;
            max_uncompressed_reg <= RST_MAX_UNCOMPRESSED;
            enforce_checksum_reg <= 1'b1;
            expect_ck_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RESERVED_BYTES:      reserved_bytes_reg   <= cfg_data[7:0];
                REG_MAX_COMPRESSED:      max_compressed_reg   <= cfg_data;
                REG_MAX_UNCOMPRESSED:    max_uncompressed_reg <= cfg_data;
                REG_ENFORCE_CHECKSUM:    enforce_checksum_reg <= cfg_data[0];
                REG_EXPECT_CK_SIGNATURE: expect_ck_reg        <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CSUM;
            byte_count_reg <= 16'd0;
            acc_reg        <= 32'd0;
            hc_reg         <= 32'd0;
            ps_reg         <= 16'd0;
            us_reg         <= 16'd0;
            sig_bad_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            acc_reg        <= acc_next;
            hc_reg         <= hc_next;
            ps_reg         <= ps_next;
            us_reg         <= us_next;
            sig_bad_reg    <= sig_bad_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && emit)
        begin
            if (out_valid_reg && !report.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && emit)
        begin
            if (out_valid_reg && !report.ready)
            begin
                skid_reg <= new_result;
            end
            else
            begin
                out_reg <= new_result;
            end
        end
    end

    assign report.valid              = out_valid_reg;
    assign report.status             = out_reg.status;
    assign report.checksum_ok        = out_reg.checksum_ok;
    assign report.stored_checksum    = out_reg.stored_checksum;
    assign report.computed_checksum  = out_reg.computed_checksum;
    assign report.compressed_bytes   = out_reg.compressed_bytes;
    assign report.uncompressed_bytes = out_reg.uncompressed_bytes;

    `DBC_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid holds an item while output register is empty")
    `DBC_ASSERT_NEXT(a_restart_after_result, accept && emit, (phase_reg == PH_CSUM) && (byte_count_reg == 16'd0) && (acc_reg == 32'd0) && !sig_bad_reg, "parser did not restart after a result")
    `DBC_ASSERT_ALWAYS(a_header_count, (phase_reg != PH_CSUM) || (byte_count_reg < 16'd4), "header byte count out of range")
    `DBC_ASSERT_ALWAYS(a_payload_count, (phase_reg != PH_PAYLOAD) || (byte_count_reg < ps_reg), "payload byte count reached the compressed size")

endmodule

/* tb/tb_cab_data_block_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cab_data_block_checker
// Streams cabinet data blocks into the checker and compares every block
// result against a cycle-free model of the parser, with random gaps on the
// byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_cab_data_block_checker;

    import cab_dbc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 20;
    localparam int RANDOM_BYTES = 250;
    localparam int NOISE_BYTES  = 160;

    typedef enum {
        PARSE_CSUM,
        PARSE_CSIZE,
        PARSE_USIZE,
        PARSE_RESERVED,
        PARSE_PAYLOAD
    } parse_phase_t;

    logic clk;
    logic rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cab_dbc_byte_if   byte_ch ();
    cab_dbc_result_if result_ch ();

    cab_data_block_checker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (byte_ch),
        .report    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register shadow
    logic [7:0]  cfg_reserved = 8'd0;
    logic [15:0] cfg_max_c    = RST_MAX_COMPRESSED;
    logic [15:0] cfg_max_u    = RST_MAX_UNCOMPRESSED;
    logic        cfg_enforce  = 1'b1;
    logic        cfg_ck       = 1'b0;

    // parser model state
    parse_phase_t pr_phase   = PARSE_CSUM;
    int           pr_count   = 0;
    logic [31:0]  pr_acc     = '0;
    logic [31:0]  pr_stored  = '0;
    logic [15:0]  pr_csize   = '0;
    logic [15:0]  pr_usize   = '0;
    logic         pr_sig_bad = 1'b0;

    result_t expected_results[$];

    int mismatches    = 0;
    int stream_bytes  = 0;
    int cycle_count   = 0;
    int tx_burst_left = 0;
    bit tx_gaps_on    = 1'b1;
    bit rx_stall_on   = 1'b1;
    int hold_req      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    task automatic block_result(input status_t st, input logic ok, input logic [31:0] sum);
        result_t r;
        r.status             = st;
        r.checksum_ok        = ok;
        r.stored_checksum    = pr_stored;
        r.computed_checksum  = sum;
        r.compressed_bytes   = pr_csize;
        r.uncompressed_bytes = pr_usize;
        expected_results.push_back(r);
        pr_phase   = PARSE_CSUM;
        pr_count   = 0;
        pr_acc     = '0;
        pr_sig_bad = 1'b0;
    endtask

    task automatic block_done();
        logic [31:0] sum;
        logic        ok;
        status_t     st;
        sum = pr_acc ^ {pr_usize, pr_csize};
        ok  = (sum == pr_stored);
        if (cfg_ck && pr_csize < 2)
            pr_sig_bad = 1'b1;
        if (!ok && cfg_enforce)
            st = ST_MISMATCH;
        else if (cfg_ck && pr_sig_bad)
            st = ST_NO_SIGNATURE;
        else
            st = ST_OK;
        block_result(st, ok, sum);
    endtask

    task automatic payload_start();
        pr_count = 0;
        if (pr_csize == 0)
            block_done();
        else
            pr_phase = PARSE_PAYLOAD;
    endtask

    task automatic track_byte(input logic [7:0] b);
        int full;
        int shift;
        case (pr_phase)
            PARSE_CSUM:
            begin
                if (pr_count == 0)
                begin
                    pr_stored = '0;
                    pr_csize  = '0;
                    pr_usize  = '0;
                end
                pr_stored[pr_count*8 +: 8] = b;
                pr_count++;
                if (pr_count >= 4)
                begin
                    pr_phase = PARSE_CSIZE;
                    pr_count = 0;
                end
            end
            PARSE_CSIZE:
            begin
                pr_csize[pr_count*8 +: 8] = b;
                pr_count++;
                if (pr_count >= 2)
                begin
                    if (pr_csize > cfg_max_c)
                        block_result(ST_CSIZE_BIG, 1'b0, '0);
                    else
                    begin
                        pr_phase = PARSE_USIZE;
                        pr_count = 0;
                    end
                end
            end
            PARSE_USIZE:
            begin
                pr_usize[pr_count*8 +: 8] = b;
                pr_count++;
                if (pr_count >= 2)
                begin
                    if (pr_usize > cfg_max_u)
                        block_result(ST_USIZE_BIG, 1'b0, '0);
                    else
                    begin
                        pr_count = 0;
                        if (cfg_reserved == 0)
                            payload_start();
                        else
                            pr_phase = PARSE_RESERVED;
                    end
                end
            end
            PARSE_RESERVED:
            begin
                pr_count++;
                if (pr_count >= int'(cfg_reserved))
                    payload_start();
            end
            PARSE_PAYLOAD:
            begin
                full = int'(pr_csize) & ~3;
                // tail bytes go in high-first
                if (pr_count < full)
                    shift = 8 * (pr_count % 4);
                else
                    shift = 8 * ((int'(pr_csize) % 4) - 1 - (pr_count - full));
                pr_acc ^= {24'd0, b} << shift;
                if (pr_count == 0 && b != CHAR_C)
                    pr_sig_bad = 1'b1;
                if (pr_count == 1 && b != CHAR_K)
                    pr_sig_bad = 1'b1;
                pr_count++;
                if (pr_count >= int'(pr_csize))
                    block_done();
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 12);
            gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        tx_burst_left--;
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        stream_bytes++;
        track_byte(value);
    endtask

    function automatic logic [31:0] block_checksum(input logic [7:0] payload[$],
                                                   input logic [15:0] csize,
                                                   input logic [15:0] usize);
        logic [31:0] sum;
        int full;
        int tail;
        sum  = '0;
        full = payload.size() & ~3;
        tail = payload.size() - full;
        for (int i = 0; i < full; i++)
            sum ^= 32'(payload[i]) << (8 * (i % 4));
        for (int i = 0; i < tail; i++)
            sum ^= 32'(payload[full + i]) << (8 * (tail - 1 - i));
        return sum ^ {usize, csize};
    endfunction

    // fill < 0 gives random payload bytes
    task automatic send_block(input logic [15:0] csize, input logic [15:0] usize,
                              input bit good_sum, input bit with_ck, input int fill);
        logic [7:0]  payload[$];
        logic [31:0] sum;
        int          n;
        n = (csize > cfg_max_c || usize > cfg_max_u) ? 0 : int'(csize);
        for (int i = 0; i < n; i++)
            payload.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        if (with_ck && n >= 1)
            payload[0] = CHAR_C;
        if (with_ck && n >= 2)
            payload[1] = CHAR_K;
        sum = block_checksum(payload, csize, usize);
        if (!good_sum)
            sum ^= 32'd1 << $urandom_range(0, 31);
        for (int i = 0; i < 4; i++)
            send_byte(sum[i*8 +: 8]);
        send_byte(csize[7:0]);
        send_byte(csize[15:8]);
        if (csize > cfg_max_c)
            return;
        send_byte(usize[7:0]);
        send_byte(usize[15:8]);
        if (usize > cfg_max_u)
            return;
        for (int i = 0; i < int'(cfg_reserved); i++)
            send_byte(8'($urandom));
        foreach (payload[i])
            send_byte(payload[i]);
    endtask

    // bring the parser back to a header, then wait for every result
    task automatic finish_phase();
        while (!(pr_phase == PARSE_CSUM && pr_count == 0))
        begin
            if (pr_phase == PARSE_CSIZE || pr_phase == PARSE_USIZE)
                send_byte(8'h00);
            else
                send_byte(8'($urandom));
        end
        byte_ch.valid <= 1'b0;
        tx_burst_left = 0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] res, input logic [15:0] maxc,
                             input logic [15:0] maxu, input logic enf, input logic ck);
        logic [CFG_INDEX_W-1:0] idx[5];
        logic [CFG_DATA_W-1:0]  val[5];
        idx = '{REG_RESERVED_BYTES, REG_MAX_COMPRESSED, REG_MAX_UNCOMPRESSED,
                REG_ENFORCE_CHECKSUM, REG_EXPECT_CK_SIGNATURE};
        val = '{16'(res), maxc, maxu, 16'(enf), 16'(ck)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_write    <= 1'b0;
        cfg_reserved = res;
        cfg_max_c    = maxc;
        cfg_max_u    = maxu;
        cfg_enforce  = enf;
        cfg_ck       = ck;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_default_blocks();
        send_block(16'd0, 16'd0, 1'b1, 1'b0, -1);
        send_block(16'd1, 16'd1, 1'b1, 1'b0, 8'hFF);
        send_block(16'd3, 16'h8000, 1'b1, 1'b0, -1);
        send_block(16'd4, 16'd4, 1'b1, 1'b0, 8'h00);
        send_block(16'd7, 16'd9, 1'b0, 1'b0, -1);
        send_block(16'd2, 16'h8001, 1'b1, 1'b0, -1);
        finish_phase();
    endtask

    task automatic test_size_limits();
        configure(8'd3, 16'd10, 16'd100, 1'b0, 1'b0);
        send_block(16'd10, 16'd100, 1'b1, 1'b0, -1);
        send_block(16'd11, 16'd0, 1'b1, 1'b0, -1);
        send_block(16'hFFFF, 16'd0, 1'b1, 1'b0, -1);
        send_block(16'd5, 16'd101, 1'b1, 1'b0, -1);
        send_block(16'd6, 16'd20, 1'b0, 1'b0, -1);
        send_block(16'd0, 16'd0, 1'b1, 1'b0, -1);
        finish_phase();
    endtask

    task automatic test_signature();
        configure(8'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_block(16'd6, 16'hFFFF, 1'b1, 1'b1, -1);
        send_block(16'd5, 16'd5, 1'b1, 1'b0, 8'h00);
        send_block(16'd3, 16'd3, 1'b1, 1'b0, CHAR_C);
        send_block(16'd1, 16'd1, 1'b1, 1'b1, -1);
        send_block(16'd0, 16'd0, 1'b1, 1'b1, -1);
        send_block(16'd4, 16'd4, 1'b0, 1'b0, 8'h11);
        finish_phase();
        // mismatch not enforced, so the bad signature shows
        configure(8'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_block(16'd4, 16'd4, 1'b0, 1'b0, 8'h11);
        send_block(16'd2, 16'd2, 1'b1, 1'b1, -1);
        finish_phase();
    endtask

    task automatic test_register_extremes();
        configure(8'd255, 16'd0, 16'd0, 1'b1, 1'b0);
        send_block(16'd0, 16'd0, 1'b1, 1'b0, -1);
        send_block(16'd1, 16'd0, 1'b1, 1'b0, -1);
        send_block(16'd0, 16'd1, 1'b1, 1'b0, -1);
        finish_phase();
        configure(8'd1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_block(16'd2, 16'hFFFF, 1'b0, 1'b0, -1);
        finish_phase();
    endtask

    task automatic test_random_blocks();
        int          start;
        logic [15:0] csize;
        logic [15:0] usize;
        start = stream_bytes;
        while (stream_bytes - start < RANDOM_BYTES)
        begin
            configure($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 40))
                                                : 8'($urandom_range(0, 2)),
                      $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 40)),
                      $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom),
                      1'($urandom), 1'($urandom));
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            for (int blk = 0; blk < 10; blk++)
            begin
                if ($urandom_range(0, 6) == 0 && cfg_max_c != 16'hFFFF)
                    csize = 16'($urandom_range(int'(cfg_max_c) + 1, 65535));
                else
                    csize = 16'($urandom_range(0, cfg_max_c < 40 ? int'(cfg_max_c) : 40));
                if ($urandom_range(0, 6) == 0 && cfg_max_u != 16'hFFFF)
                    usize = 16'($urandom_range(int'(cfg_max_u) + 1, 65535));
                else
                    usize = 16'($urandom_range(0, int'(cfg_max_u)));
                send_block(csize, usize, $urandom_range(0, 6) != 0,
                           cfg_ck ? ($urandom_range(0, 4) != 0) : 1'($urandom), -1);
            end
            finish_phase();
        end
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // unframed bytes: the parser resyncs through size errors
    task automatic test_stream_noise();
        configure(8'($urandom_range(0, 3)), 16'd16, 16'h0800, 1'b1, 1'($urandom));
        for (int i = 0; i < NOISE_BYTES; i++)
            send_byte(8'($urandom));
        finish_phase();
    endtask

    // receiver holds off while short blocks keep coming
    task automatic test_backpressure();
        configure(8'd0, 16'hFFFF, 16'h8000, 1'b1, 1'b0);
        tx_gaps_on = 1'b0;
        hold_req++;
        for (int blk = 0; blk < 12; blk++)
            send_block(16'($urandom_range(0, 2)), 16'($urandom), 1'b1, 1'b0, -1);
        finish_phase();
        tx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_seen;
        int hold_left;
        int run_left;
        bit stalling;
        hold_seen = 0;
        hold_left = 0;
        run_left  = 0;
        stalling  = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 8);
                    stalling = rx_stall_on && ($urandom_range(0, 2) == 0);
                end
                run_left--;
                result_ch.ready <= !stalling;
            end
        end
    end

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with none expected, stored 0x%0h",
                                              result_ch.stored_checksum));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(result_ch.status), 32'(want.status));
                    check_field("checksum_ok", 32'(result_ch.checksum_ok),
                                32'(want.checksum_ok));
                    check_field("stored_checksum", result_ch.stored_checksum,
                                want.stored_checksum);
                    check_field("computed_checksum", result_ch.computed_checksum,
                                want.computed_checksum);
                    check_field("compressed_bytes", 32'(result_ch.compressed_bytes),
                                32'(want.compressed_bytes));
                    check_field("uncompressed_bytes", 32'(result_ch.uncompressed_bytes),
                                32'(want.uncompressed_bytes));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cab_data_block_checker test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        cfg_write         <= 1'b0;
        cfg_index         <= REG_RESERVED_BYTES;
        cfg_data          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_blocks();
        test_size_limits();
        test_signature();
        test_register_extremes();
        test_backpressure();
        test_random_blocks();
        test_stream_noise();

        repeat (END_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_results.size()));
        if (mismatches == 0)
            $display("cab_data_block_checker test passed");
        else
            $display("cab_data_block_checker test failed");
        $finish;
    end

endmodule
